>>> hw/rtl/ffpa_pkg.sv
// shared constants, codes and types of the first-fit page allocator
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam int MAX_PAGES   = 4096;
  localparam int MAX_HOLES   = 32;
  localparam int MAX_REGIONS = 32;

  localparam int PAGE_W = 13;
  localparam int BASE_W = 12;
  localparam int PID_W  = 16;
  localparam int LP_W   = 12;
  localparam int HAW    = $clog2(MAX_HOLES);
  localparam int RAW    = $clog2(MAX_REGIONS);
  localparam int IDX_W  = ((HAW > RAW) ? HAW : RAW) + 1;

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_XLATE   = 2'd2;
  localparam logic [1:0] CMD_COMPACT = 2'd3;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FRAG     = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // source of a single result word
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_BL   = 2'd1;
  localparam logic [1:0] SRC_XLT  = 2'd2;

  // table read pointer selection
  localparam logic [1:0] RD_CUR  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_PREV = 2'd2;

  // datapath operations
  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_INC        = 5'd2;
  localparam logic [4:0] OP_AL_PICK    = 5'd3;
  localparam logic [4:0] OP_HDOWN      = 5'd4;
  localparam logic [4:0] OP_HDEC_Z     = 5'd5;
  localparam logic [4:0] OP_HDEC_R     = 5'd6;
  localparam logic [4:0] OP_SETPOS_R   = 5'd7;
  localparam logic [4:0] OP_RUP        = 5'd8;
  localparam logic [4:0] OP_RINS       = 5'd9;
  localparam logic [4:0] OP_REL_PICK   = 5'd10;
  localparam logic [4:0] OP_SETLR      = 5'd11;
  localparam logic [4:0] OP_MERGE_BOTH = 5'd12;
  localparam logic [4:0] OP_MERGE_L    = 5'd13;
  localparam logic [4:0] OP_MERGE_R    = 5'd14;
  localparam logic [4:0] OP_HUP_INIT   = 5'd15;
  localparam logic [4:0] OP_HUP        = 5'd16;
  localparam logic [4:0] OP_HINS       = 5'd17;
  localparam logic [4:0] OP_RDOWN      = 5'd18;
  localparam logic [4:0] OP_RDEC       = 5'd19;
  localparam logic [4:0] OP_CMP_INIT   = 5'd20;
  localparam logic [4:0] OP_CMP_STEP   = 5'd21;
  localparam logic [4:0] OP_EMIT       = 5'd22;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] st;
    logic [1:0] src;
    logic [1:0] h_sel;
    logic [1:0] r_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       req_zero;
    logic       req_gt_free;
    logic       rc_zero;
    logic       rc_full;
    logic       hc_full;
    logic       h_end;
    logic       r_end;
    logic       h_fit;
    logic       h_exact;
    logic       h_after;
    logic       r_match;
    logic       r_after;
    logic       left;
    logic       right;
    logic       hdown_done;
    logic       rdown_done;
    logic       up_done;
    logic       out_free;
    logic       cmp_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/ffpa_ctrl.sv
// sequencer that walks the hole and region tables for each command
`timescale 1ns / 1ps
module ffpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ffpa_pkg::dp_stat_t stat_i,
  output ffpa_pkg::dp_cmd_t  cmd_o
);
  import ffpa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_AFIT  = 4'd2;
  localparam logic [3:0] S_AHREM = 4'd3;
  localparam logic [3:0] S_APOS  = 4'd4;
  localparam logic [3:0] S_AUP   = 4'd5;
  localparam logic [3:0] S_RFIND = 4'd6;
  localparam logic [3:0] S_RHOLE = 4'd7;
  localparam logic [3:0] S_RDEC  = 4'd8;
  localparam logic [3:0] S_RHUP  = 4'd9;
  localparam logic [3:0] S_RHREM = 4'd10;
  localparam logic [3:0] S_RRREM = 4'd11;
  localparam logic [3:0] S_CMP   = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] est_q, est_d;
  logic [1:0] esrc_q, esrc_d;

  // read pointer selection follows the state only
  always_comb begin
    cmd_o.h_sel = RD_CUR;
    cmd_o.r_sel = RD_CUR;
    if (state_q == S_AHREM || state_q == S_RHREM) begin
      cmd_o.h_sel = RD_NEXT;
    end
    if (state_q == S_RHUP) begin
      cmd_o.h_sel = RD_PREV;
    end
    if (state_q == S_AUP) begin
      cmd_o.r_sel = RD_PREV;
    end
    if (state_q == S_RRREM) begin
      cmd_o.r_sel = RD_NEXT;
    end
  end

  // next state and operation
  always_comb begin
    state_d    = state_q;
    est_d      = est_q;
    esrc_d     = esrc_q;
    cmd_o.op   = OP_NOP;
    cmd_o.st   = est_q;
    cmd_o.src  = esrc_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.cmd)
          CMD_ALLOC: begin
            if (stat_i.req_zero || stat_i.req_gt_free) begin
              est_d = ST_NOSPACE; esrc_d = SRC_ZERO; state_d = S_EMIT;
            end else begin
              state_d = S_AFIT;
            end
          end
          CMD_RELEASE, CMD_XLATE: state_d = S_RFIND;
          default: begin
            if (stat_i.rc_zero) begin
              est_d = ST_OK; esrc_d = SRC_ZERO; state_d = S_EMIT;
            end else begin
              cmd_o.op = OP_CMP_INIT;
              state_d  = S_CMP;
            end
          end
        endcase
      end
      S_AFIT: begin
        priority if (stat_i.h_end) begin
          est_d = ST_FRAG; esrc_d = SRC_ZERO; state_d = S_EMIT;
        end else if (stat_i.h_fit) begin
          if (stat_i.rc_full) begin
            est_d = ST_NOSPACE; esrc_d = SRC_ZERO; state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_AL_PICK;
            state_d  = stat_i.h_exact ? S_AHREM : S_APOS;
          end
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_AHREM: begin
        if (stat_i.hdown_done) begin
          cmd_o.op = OP_HDEC_Z; state_d = S_APOS;
        end else begin
          cmd_o.op = OP_HDOWN;
        end
      end
      S_APOS: begin
        if (stat_i.r_end || stat_i.r_after) begin
          cmd_o.op = OP_SETPOS_R; state_d = S_AUP;
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_AUP: begin
        if (stat_i.up_done) begin
          cmd_o.op = OP_RINS;
          est_d = ST_OK; esrc_d = SRC_BL; state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_RUP;
        end
      end
      S_RFIND: begin
        priority if (stat_i.r_end) begin
          est_d = ST_NOTFOUND; esrc_d = SRC_ZERO; state_d = S_EMIT;
        end else if (stat_i.r_match) begin
          if (stat_i.cmd == CMD_XLATE) begin
            est_d = ST_OK; esrc_d = SRC_XLT; state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_REL_PICK; state_d = S_RHOLE;
          end
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_RHOLE: begin
        if (stat_i.h_end || stat_i.h_after) begin
          cmd_o.op = OP_SETLR; state_d = S_RDEC;
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_RDEC: begin
        priority if (stat_i.left && stat_i.right) begin
          cmd_o.op = OP_MERGE_BOTH; state_d = S_RHREM;
        end else if (stat_i.left) begin
          cmd_o.op = OP_MERGE_L; state_d = S_RRREM;
        end else if (stat_i.right) begin
          cmd_o.op = OP_MERGE_R; state_d = S_RRREM;
        end else if (stat_i.hc_full) begin
          est_d = ST_NOSPACE; esrc_d = SRC_BL; state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_HUP_INIT; state_d = S_RHUP;
        end
      end
      S_RHUP: begin
        if (stat_i.up_done) begin
          cmd_o.op = OP_HINS; state_d = S_RRREM;
        end else begin
          cmd_o.op = OP_HUP;
        end
      end
      S_RHREM: begin
        if (stat_i.hdown_done) begin
          cmd_o.op = OP_HDEC_R; state_d = S_RRREM;
        end else begin
          cmd_o.op = OP_HDOWN;
        end
      end
      S_RRREM: begin
        if (stat_i.rdown_done) begin
          cmd_o.op = OP_RDEC;
          est_d = ST_OK; esrc_d = SRC_BL; state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_RDOWN;
        end
      end
      S_CMP: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_CMP_STEP;
          if (stat_i.cmp_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      est_q   <= ST_OK;
      esrc_q  <= SRC_ZERO;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      esrc_q  <= esrc_d;
    end
  end

endmodule

>>> hw/rtl/ffpa_dp.sv
// hole and region tables, scan pointer and result register
`timescale 1ns / 1ps
module ffpa_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffpa_pkg::dp_cmd_t            cmd_i,
  output ffpa_pkg::dp_stat_t           stat_o,
  input  logic [1:0]                   command_i,
  input  logic [ffpa_pkg::PID_W-1:0]   process_id_i,
  input  logic [ffpa_pkg::PAGE_W-1:0]  page_count_i,
  input  logic [ffpa_pkg::LP_W-1:0]    logical_page_i,
  input  logic                         cfg_we_i,
  input  logic [ffpa_pkg::PAGE_W-1:0]  cfg_total_i,
  output logic [ffpa_pkg::PAGE_W-1:0]  total_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [ffpa_pkg::BASE_W-1:0]  region_base_o,
  output logic [ffpa_pkg::PAGE_W-1:0]  region_pages_o,
  output logic [ffpa_pkg::BASE_W-1:0]  old_base_o,
  output logic [ffpa_pkg::PID_W-1:0]   result_process_o,
  output logic [ffpa_pkg::PAGE_W-1:0]  free_pages_o,
  output logic                         last_o
);
  import ffpa_pkg::*;

  // tables
  logic [BASE_W-1:0] hb_q [MAX_HOLES];
  logic [PAGE_W-1:0] hl_q [MAX_HOLES];
  logic [PID_W-1:0]  ro_q [MAX_REGIONS];
  logic [BASE_W-1:0] rs_q [MAX_REGIONS];
  logic [PAGE_W-1:0] rl_q [MAX_REGIONS];

  // control and working registers
  logic [IDX_W-1:0]  hc_q, hc_d, rc_q, rc_d, idx_q, idx_d, pos_q, pos_d, rpos_q, rpos_d;
  logic [PAGE_W-1:0] free_q, free_d, total_q, total_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [PID_W-1:0]  pid_q, pid_d;
  logic [PAGE_W-1:0] req_q, req_d;
  logic [LP_W-1:0]   lp_q, lp_d;
  logic [BASE_W-1:0] b_q, b_d;
  logic [PAGE_W-1:0] l_q, l_d, prev_end_q, prev_end_d, prev_len_q, prev_len_d;
  logic [PAGE_W-1:0] cur_len_q, cur_len_d, next_q, next_d;
  logic              left_q, left_d, right_q, right_d;

  // result register
  logic              ov_q, ov_d, olast_q, olast_d;
  logic [1:0]        ost_q, ost_d;
  logic [BASE_W-1:0] obase_q, obase_d, oold_q, oold_d;
  logic [PAGE_W-1:0] opages_q, opages_d, ofree_q, ofree_d;
  logic [PID_W-1:0]  oproc_q, oproc_d;

  // table write ports
  logic              hb_we, hl_we, ro_we, rs_we, rl_we;
  logic [HAW-1:0]    h_wa;
  logic [RAW-1:0]    r_wa;
  logic [BASE_W-1:0] hb_wd, rs_wd;
  logic [PAGE_W-1:0] hl_wd, rl_wd;
  logic [PID_W-1:0]  ro_wd;

  // single read port per table group
  logic [IDX_W-1:0]  idx_p1, idx_m1, pos_m1;
  logic [HAW-1:0]    h_ra;
  logic [RAW-1:0]    r_ra;
  logic [BASE_W-1:0] h_rb, r_rs;
  logic [PAGE_W-1:0] h_rl, r_rl;
  logic [PID_W-1:0]  r_ro;
  logic              out_free;

  assign idx_p1 = idx_q + IDX_W'(1);
  assign idx_m1 = idx_q - IDX_W'(1);
  assign pos_m1 = pos_q - IDX_W'(1);

  always_comb begin
    unique case (cmd_i.h_sel)
      RD_NEXT: h_ra = idx_p1[HAW-1:0];
      RD_PREV: h_ra = idx_m1[HAW-1:0];
      default: h_ra = idx_q[HAW-1:0];
    endcase
    unique case (cmd_i.r_sel)
      RD_NEXT: r_ra = idx_p1[RAW-1:0];
      RD_PREV: r_ra = idx_m1[RAW-1:0];
      default: r_ra = idx_q[RAW-1:0];
    endcase
  end

  assign h_rb = hb_q[h_ra];
  assign h_rl = hl_q[h_ra];
  assign r_ro = ro_q[r_ra];
  assign r_rs = rs_q[r_ra];
  assign r_rl = rl_q[r_ra];

  assign out_free = !ov_q || out_ready_i;

  // status toward the sequencer
  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.req_zero    = (req_q == '0);
    stat_o.req_gt_free = (req_q > free_q);
    stat_o.rc_zero     = (rc_q == '0);
    stat_o.rc_full     = (rc_q >= IDX_W'(MAX_REGIONS));
    stat_o.hc_full     = (hc_q >= IDX_W'(MAX_HOLES));
    stat_o.h_end       = (idx_q >= hc_q);
    stat_o.r_end       = (idx_q >= rc_q);
    stat_o.h_fit       = (h_rl >= req_q);
    stat_o.h_exact     = (h_rl == req_q);
    stat_o.h_after     = (h_rb > b_q);
    stat_o.r_match     = (r_ro == pid_q);
    stat_o.r_after     = (r_rs > b_q);
    stat_o.left        = left_q;
    stat_o.right       = right_q;
    stat_o.hdown_done  = (idx_p1 >= hc_q);
    stat_o.rdown_done  = (idx_p1 >= rc_q);
    stat_o.up_done     = (idx_q == pos_q);
    stat_o.out_free    = out_free;
    stat_o.cmp_last    = (idx_p1 == rc_q);
  end

  // operation decode
  always_comb begin
    hc_d = hc_q; rc_d = rc_q; idx_d = idx_q; pos_d = pos_q; rpos_d = rpos_q;
    free_d = free_q; total_d = total_q;
    cmd_d = cmd_q; pid_d = pid_q; req_d = req_q; lp_d = lp_q;
    b_d = b_q; l_d = l_q; prev_end_d = prev_end_q; prev_len_d = prev_len_q;
    cur_len_d = cur_len_q; next_d = next_q; left_d = left_q; right_d = right_q;
    ov_d = ov_q && !out_ready_i;
    ost_d = ost_q; obase_d = obase_q; opages_d = opages_q; oold_d = oold_q;
    oproc_d = oproc_q; ofree_d = ofree_q; olast_d = olast_q;
    hb_we = 1'b0; hl_we = 1'b0; ro_we = 1'b0; rs_we = 1'b0; rl_we = 1'b0;
    h_wa = idx_q[HAW-1:0]; r_wa = idx_q[RAW-1:0];
    hb_wd = h_rb; hl_wd = h_rl; ro_wd = r_ro; rs_wd = r_rs; rl_wd = r_rl;
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_d = command_i; pid_d = process_id_i; req_d = page_count_i;
        lp_d = logical_page_i; idx_d = '0;
      end
      OP_INC: begin
        prev_end_d = PAGE_W'({1'b0, h_rb} + h_rl);
        prev_len_d = h_rl;
        idx_d      = idx_p1;
      end
      OP_AL_PICK: begin
        b_d = h_rb; l_d = req_q; pos_d = idx_q;
        free_d = free_q - req_q;
        if (h_rl != req_q) begin
          hb_we = 1'b1; hb_wd = BASE_W'({1'b0, h_rb} + req_q);
          hl_we = 1'b1; hl_wd = h_rl - req_q;
          idx_d = '0;
        end
      end
      OP_HDOWN: begin
        hb_we = 1'b1; hl_we = 1'b1; idx_d = idx_p1;
      end
      OP_HDEC_Z: begin
        hc_d = hc_q - IDX_W'(1); idx_d = '0;
      end
      OP_HDEC_R: begin
        hc_d = hc_q - IDX_W'(1); idx_d = rpos_q;
      end
      OP_SETPOS_R: begin
        pos_d = idx_q; idx_d = rc_q;
      end
      OP_RUP: begin
        ro_we = 1'b1; rs_we = 1'b1; rl_we = 1'b1; idx_d = idx_m1;
      end
      OP_RINS: begin
        r_wa = pos_q[RAW-1:0];
        ro_we = 1'b1; ro_wd = pid_q;
        rs_we = 1'b1; rs_wd = b_q;
        rl_we = 1'b1; rl_wd = l_q;
        rc_d = rc_q + IDX_W'(1);
      end
      OP_REL_PICK: begin
        b_d = r_rs; l_d = r_rl; rpos_d = idx_q; idx_d = '0;
      end
      OP_SETLR: begin
        pos_d     = idx_q;
        left_d    = (idx_q != '0) && (prev_end_q == {1'b0, b_q});
        right_d   = (idx_q < hc_q) && ({1'b0, h_rb} == PAGE_W'({1'b0, b_q} + l_q));
        cur_len_d = h_rl;
      end
      OP_MERGE_BOTH: begin
        h_wa = pos_m1[HAW-1:0];
        hl_we = 1'b1; hl_wd = PAGE_W'(prev_len_q + l_q + cur_len_q);
        idx_d = pos_q;
      end
      OP_MERGE_L: begin
        h_wa = pos_m1[HAW-1:0];
        hl_we = 1'b1; hl_wd = PAGE_W'(prev_len_q + l_q);
        idx_d = rpos_q;
      end
      OP_MERGE_R: begin
        h_wa = pos_q[HAW-1:0];
        hb_we = 1'b1; hb_wd = b_q;
        hl_we = 1'b1; hl_wd = PAGE_W'(cur_len_q + l_q);
        idx_d = rpos_q;
      end
      OP_HUP_INIT: idx_d = hc_q;
      OP_HUP: begin
        hb_we = 1'b1; hl_we = 1'b1; idx_d = idx_m1;
      end
      OP_HINS: begin
        h_wa = pos_q[HAW-1:0];
        hb_we = 1'b1; hb_wd = b_q;
        hl_we = 1'b1; hl_wd = l_q;
        hc_d = hc_q + IDX_W'(1); idx_d = rpos_q;
      end
      OP_RDOWN: begin
        ro_we = 1'b1; rs_we = 1'b1; rl_we = 1'b1; idx_d = idx_p1;
      end
      OP_RDEC: begin
        rc_d = rc_q - IDX_W'(1); free_d = free_q + l_q;
      end
      OP_CMP_INIT: begin
        h_wa = '0;
        hb_we = 1'b1; hb_wd = BASE_W'(total_q - free_q);
        hl_we = 1'b1; hl_wd = free_q;
        hc_d = (free_q != '0) ? IDX_W'(1) : '0;
        idx_d = '0; next_d = '0;
      end
      OP_CMP_STEP: begin
        ov_d = 1'b1; ost_d = ST_OK;
        obase_d = next_q[BASE_W-1:0]; opages_d = r_rl; oold_d = r_rs;
        oproc_d = r_ro; ofree_d = free_q; olast_d = (idx_p1 == rc_q);
        rs_we = 1'b1; rs_wd = next_q[BASE_W-1:0];
        next_d = next_q + r_rl; idx_d = idx_p1;
      end
      OP_EMIT: begin
        ov_d = 1'b1; ost_d = cmd_i.st; oold_d = '0; oproc_d = '0;
        ofree_d = free_q; olast_d = 1'b1;
        unique case (cmd_i.src)
          SRC_BL: begin
            obase_d = b_q; opages_d = l_q;
          end
          SRC_XLT: begin
            obase_d = BASE_W'(r_rs + lp_q); opages_d = r_rl;
          end
          default: begin
            obase_d = '0; opages_d = '0;
          end
        endcase
      end
      default: ;
    endcase
    // register write clears both tables
    if (cfg_we_i) begin
      total_d = cfg_total_i; free_d = cfg_total_i;
      hc_d = IDX_W'(1); rc_d = '0;
      h_wa = '0;
      hb_we = 1'b1; hb_wd = '0;
      hl_we = 1'b1; hl_wd = cfg_total_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q    <= IDX_W'(1);
      rc_q    <= '0;
      idx_q   <= '0;
      free_q  <= PAGE_W'(MAX_PAGES);
      total_q <= PAGE_W'(MAX_PAGES);
      ov_q    <= 1'b0;
    end else begin
      hc_q    <= hc_d;
      rc_q    <= rc_d;
      idx_q   <= idx_d;
      free_q  <= free_d;
      total_q <= total_d;
      ov_q    <= ov_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; rpos_q <= rpos_d;
    cmd_q <= cmd_d; pid_q <= pid_d; req_q <= req_d; lp_q <= lp_d;
    b_q <= b_d; l_q <= l_d; prev_end_q <= prev_end_d; prev_len_q <= prev_len_d;
    cur_len_q <= cur_len_d; next_q <= next_d; left_q <= left_d; right_q <= right_d;
    ost_q <= ost_d; obase_q <= obase_d; opages_q <= opages_d; oold_q <= oold_d;
    oproc_q <= oproc_d; ofree_q <= ofree_d; olast_q <= olast_d;
  end

  // hole table, first hole holds the whole area after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q[0] <= '0;
      hl_q[0] <= PAGE_W'(MAX_PAGES);
    end else begin
      if (hb_we) hb_q[h_wa] <= hb_wd;
      if (hl_we) hl_q[h_wa] <= hl_wd;
    end
  end

  // region table
  always_ff @(posedge clk_i) begin
    if (ro_we) ro_q[r_wa] <= ro_wd;
    if (rs_we) rs_q[r_wa] <= rs_wd;
    if (rl_we) rl_q[r_wa] <= rl_wd;
  end

  assign total_o          = total_q;
  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign region_base_o    = obase_q;
  assign region_pages_o   = opages_q;
  assign old_base_o       = oold_q;
  assign result_process_o = oproc_q;
  assign free_pages_o     = ofree_q;
  assign last_o           = olast_q;

endmodule

>>> hw/rtl/first_fit_page_allocator_top.sv
// First-fit page allocator for a swap area.
// Input channel (in_valid_i/in_ready_o) takes one command word: allocate,
// release, translate or compact, with process id, page count and logical
// page. Output channel (out_valid_o/out_ready_i) gives result words; each
// command gives one word, compact one word per used region or one word when
// there are none, and last_o marks the final word of a command.
// Commands are handled one at a time by a sequencer that steps through the
// hole and region tables one entry per clock, while compact waits whenever
// the output register is still full. After a command is accepted it is
// decoded, the tables are searched and shifted as needed, and then the first
// word is registered. Compact gives one word per cycle after the first while
// the receiver takes them.
// The next command can be taken in the cycle in which the last word sits in
// the output register; a stalled receiver holds that word and stalls the
// sequencer only when it needs to emit another.
// Reset: one hole covers all 4096 pages, no regions. The total_pages
// register at byte address 0 (APB) sets the area size, clamped to 1..4096,
// and clears both tables; write it only while the block is idle.
`timescale 1ns / 1ps
module first_fit_page_allocator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [ffpa_pkg::PID_W-1:0]   process_id_i,
  input  logic [ffpa_pkg::PAGE_W-1:0]  page_count_i,
  input  logic [ffpa_pkg::LP_W-1:0]    logical_page_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [ffpa_pkg::BASE_W-1:0]  region_base_o,
  output logic [ffpa_pkg::PAGE_W-1:0]  region_pages_o,
  output logic [ffpa_pkg::BASE_W-1:0]  old_base_o,
  output logic [ffpa_pkg::PID_W-1:0]   result_process_o,
  output logic [ffpa_pkg::PAGE_W-1:0]  free_pages_o,
  output logic                         last_o
);
  import ffpa_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              cfg_we;
  logic [PAGE_W-1:0] cfg_raw, cfg_total, total;

  // register write decode and clamp
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && !paddr[2];
  assign cfg_raw = pwdata[PAGE_W-1:0];
  always_comb begin
    priority if (cfg_raw == '0) begin
      cfg_total = PAGE_W'(1);
    end else if (cfg_raw > PAGE_W'(MAX_PAGES)) begin
      cfg_total = PAGE_W'(MAX_PAGES);
    end else begin
      cfg_total = cfg_raw;
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {{(32 - PAGE_W){1'b0}}, total};

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffpa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .command_i        (command_i),
    .process_id_i     (process_id_i),
    .page_count_i     (page_count_i),
    .logical_page_i   (logical_page_i),
    .cfg_we_i         (cfg_we),
    .cfg_total_i      (cfg_total),
    .total_o          (total),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .region_base_o    (region_base_o),
    .region_pages_o   (region_pages_o),
    .old_base_o       (old_base_o),
    .result_process_o (result_process_o),
    .free_pages_o     (free_pages_o),
    .last_o           (last_o)
  );

endmodule
